### hw/rtl/base32_stream_encoder_top_assert.svh
// assertion macros for the base32 stream encoder
`ifndef BASE32_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE32_STREAM_ENCODER_TOP_ASSERT_SVH

// checked on every clock edge outside reset
`define B32_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define B32_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/b32enc_pkg.sv
package b32enc_pkg;

  localparam logic [6:0] CHAR_NEWLINE = 7'h0a;
  localparam logic [6:0] CHAR_PAD     = 7'h3d;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_UPPER_Z = 7'h5a;
  localparam logic [6:0] CHAR_DIGIT_2 = 7'h32;
  localparam logic [6:0] CHAR_DIGIT_7 = 7'h37;

  localparam logic [1:0] CFG_PAD_ENABLE        = 2'd0;
  localparam logic [1:0] CFG_LINE_BREAK_ENABLE = 2'd1;

  typedef struct packed {
    logic [11:0] acc;
    logic [3:0]  pend;
    logic [2:0]  grp;
    logic        any;
    logic        nl_done;
    logic        fin;
  } msg_state_t;

  function automatic logic [6:0] symbol(input logic [4:0] v);
    logic [6:0] ch;
    if (v < 5'd26) begin
      ch = CHAR_UPPER_A + {2'b00, v};
    end else begin
      ch = CHAR_DIGIT_2 + {2'b00, v - 5'd26};
    end
    return ch;
  endfunction

endpackage

### hw/rtl/b32enc_step.sv
module b32enc_step #(
  parameter int LINE_LENGTH = 64,
  parameter int LP_W        = 6
) (
  input  b32enc_pkg::msg_state_t st,
  input  logic [LP_W-1:0]        line_pos,
  input  logic                   pad_en,
  input  logic                   lb_en,
  output b32enc_pkg::msg_state_t st_nxt,
  output logic [LP_W-1:0]        line_pos_nxt,
  output logic [6:0]             ch,
  output logic                   is_last
);
  import b32enc_pkg::*;

  logic       need_nl;
  logic [2:0] sh_dn;
  logic [2:0] sh_up;
  logic [4:0] shifted;
  logic [4:0] flush_val;
  logic [3:0] pend_new;
  logic [2:0] grp_new;
  logic       more;

  assign need_nl   = lb_en && st.any && (line_pos == '0) && !st.nl_done;
  assign sh_dn     = 3'(st.pend - 4'd5);
  assign sh_up     = 3'(4'd5 - st.pend);
  assign shifted   = 5'(st.acc >> sh_dn);
  assign flush_val = st.acc[4:0] << sh_up;
  assign grp_new   = st.grp + 3'd1;

  always_comb begin
    st_nxt       = st;
    line_pos_nxt = line_pos;
    ch           = CHAR_NEWLINE;
    is_last      = 1'b0;
    pend_new     = st.pend;
    more         = 1'b0;
    if (need_nl) begin
      st_nxt.nl_done = 1'b1;
    end else begin
      if (st.pend >= 4'd5) begin
        ch       = symbol(shifted);
        pend_new = st.pend - 4'd5;
      end else if (st.pend != 4'd0) begin
        ch       = symbol(flush_val);
        pend_new = 4'd0;
      end else begin
        ch = CHAR_PAD;
      end
      more = (pend_new >= 4'd5) ||
             (st.fin && ((pend_new != 4'd0) || (pad_en && (grp_new != 3'd0))));
      is_last        = !more;
      st_nxt.pend    = pend_new;
      st_nxt.grp     = grp_new;
      st_nxt.any     = 1'b1;
      st_nxt.nl_done = 1'b0;
      line_pos_nxt   = (line_pos == LP_W'(LINE_LENGTH - 1)) ? '0 : line_pos + 1'b1;
      if (!more && st.fin) begin
        st_nxt       = '0;
        line_pos_nxt = '0;
      end
    end
  end

endmodule

### hw/rtl/base32_stream_encoder_top.sv
// base32 stream encoder, RFC 4648 alphabet
// input channel: one byte per item (in_data_byte), in_final_byte marks the
// last byte of a message. output channel: one ASCII character per item
// (out_char) with out_run_last high on the last character caused by a byte.
// a byte yields one or two characters, a newline before a character at a
// nonzero multiple of LINE_LENGTH when line breaks are on, and on the final
// byte a flushed character and, if padding is on, '=' up to a group of 8.
// configuration: cfg_we with cfg_index and cfg_wdata, write only while idle.
// the byte is first registered in the message state; its first character
// then moves into the output register once that register is free.
// throughput: one character per cycle while out_ready is high; a byte
// causes 1 to 3 characters, up to 9 on a final byte if LINE_LENGTH >= 8;
// the next byte is taken at the edge that moves the last character of the
// current one into the output register.
// reset: output empty, message state cleared, padding on, line breaks off.
// stall: while out_ready is low the output register holds its character,
// the byte in progress waits and in_ready stays low until its work is done.
module base32_stream_encoder_top #(
  parameter int LINE_LENGTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_run_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_wdata
);
  import b32enc_pkg::*;

  localparam int LP_W = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;

  msg_state_t      st_r, st_nxt, st_step, st_base;
  logic [LP_W-1:0] line_pos_r, line_pos_nxt, line_pos_step, line_pos_base;
  logic            busy_r, busy_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [6:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;
  logic            pad_en_r, pad_en_nxt;
  logic            lb_en_r, lb_en_nxt;
  logic [6:0]      step_char;
  logic            step_last;
  logic            step;
  logic            in_acc;

  b32enc_step #(
    .LINE_LENGTH (LINE_LENGTH),
    .LP_W        (LP_W)
  ) u_step (
    .st           (st_r),
    .line_pos     (line_pos_r),
    .pad_en       (pad_en_r),
    .lb_en        (lb_en_r),
    .st_nxt       (st_step),
    .line_pos_nxt (line_pos_step),
    .ch           (step_char),
    .is_last      (step_last)
  );

  assign step     = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (step && step_last);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    st_base       = step ? st_step : st_r;
    line_pos_base = step ? line_pos_step : line_pos_r;
    st_nxt        = st_base;
    line_pos_nxt  = line_pos_base;
    if (in_acc) begin
      st_nxt.acc     = {st_base.acc[3:0], in_data_byte};
      st_nxt.pend    = st_base.pend + 4'd8;
      st_nxt.fin     = in_final_byte;
      st_nxt.nl_done = 1'b0;
    end
    busy_nxt = in_acc ? 1'b1 : ((step && step_last) ? 1'b0 : busy_r);
    out_valid_nxt = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_char_nxt  = step ? step_char : out_char_r;
    out_last_nxt  = step ? step_last : out_last_r;
    pad_en_nxt    = pad_en_r;
    lb_en_nxt     = lb_en_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PAD_ENABLE:        pad_en_nxt = cfg_wdata;
        CFG_LINE_BREAK_ENABLE: lb_en_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      line_pos_r  <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pad_en_r    <= 1'b1;
      lb_en_r     <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      line_pos_r  <= line_pos_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      pad_en_r    <= pad_en_nxt;
      lb_en_r     <= lb_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_run_last = out_last_r;

endmodule

### hw/rtl/b32enc_checker.sv
`include "base32_stream_encoder_top_assert.svh"

module b32enc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       out_run_last
);
  import b32enc_pkg::*;

  `B32_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_run_last),
    "stalled output item changed")
  `B32_ASSERT(a_newline_not_last,
    out_valid && (out_char == CHAR_NEWLINE) |-> !out_run_last,
    "newline marked as last of a byte")
  `B32_ASSERT(a_char_set,
    out_valid |-> ((out_char >= CHAR_UPPER_A) && (out_char <= CHAR_UPPER_Z)) ||
      ((out_char >= CHAR_DIGIT_2) && (out_char <= CHAR_DIGIT_7)) ||
      (out_char == CHAR_PAD) || (out_char == CHAR_NEWLINE),
    "character outside the output set")
  `B32_ASSERT(a_item_yields, in_valid && in_ready |-> ##2 out_valid,
    "accepted byte produced no output")
  `B32_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid straight after reset")

endmodule

bind base32_stream_encoder_top b32enc_checker u_b32enc_checker (.*);

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b32enc_pkg::*;

  localparam int LINE_LEN = 64;
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;
  localparam int PHASE_ITEMS = 50;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } enc_char_t;

  class base32_checker;
    string       alpha_tab = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    logic [11:0] acc;
    int unsigned pend;
    int unsigned line_pos;
    int unsigned grp;
    bit          any_out;
    bit          pad_en;
    bit          lb_en;
    enc_char_t   pending_chars[$];
    int          errors;

    function new();
      pad_en = 1'b1;
      lb_en  = 1'b0;
      errors = 0;
      clear_msg();
    endfunction

    function void clear_msg();
      acc      = '0;
      pend     = 0;
      line_pos = 0;
      grp      = 0;
      any_out  = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic v);
      case (idx)
        CFG_PAD_ENABLE:        pad_en = v;
        CFG_LINE_BREAK_ENABLE: lb_en  = v;
        default: ;
      endcase
    endfunction

    function logic [6:0] alphabet(logic [4:0] v);
      return 7'(alpha_tab[v]);
    endfunction

    function void emit(logic [6:0] c);
      if (lb_en && any_out && line_pos == 0) begin
        pending_chars.push_back('{ch: CHAR_NEWLINE, last: 1'b0});
      end
      pending_chars.push_back('{ch: c, last: 1'b0});
      any_out  = 1'b1;
      line_pos = (line_pos + 1) % LINE_LEN;
      grp      = (grp + 1) % 8;
    endfunction

    function void take_byte(logic [7:0] b, logic f);
      logic [11:0] sym;
      acc  = {acc[3:0], b};
      pend = pend + 8;
      while (pend >= 5) begin
        pend = pend - 5;
        sym  = acc >> pend;
        emit(alphabet(sym[4:0]));
      end
      acc = acc & ((12'd1 << pend) - 12'd1);
      if (f) begin
        if (pend != 0) begin
          sym = acc << (5 - pend);
          emit(alphabet(sym[4:0]));
        end
        if (pad_en) begin
          while (grp != 0) emit(CHAR_PAD);
        end
        clear_msg();
      end
      pending_chars[pending_chars.size() - 1].last = 1'b1;
    endfunction

    function void match_char(logic [6:0] c, logic l);
      enc_char_t e;
      if (pending_chars.size() == 0) begin
        $display("%0t unexpected char: expected none, got char %h last %b", $time, c, l);
        errors++;
      end else begin
        e = pending_chars.pop_front();
        if (e.ch !== c || e.last !== l) begin
          $display("%0t mismatch: expected char %h last %b, got char %h last %b",
                   $time, e.ch, e.last, c, l);
          errors++;
        end
      end
    endfunction

    function int waiting();
      return pending_chars.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_final_byte;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] out_char;
  logic       out_run_last;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic       cfg_wdata;

  base32_checker sb;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_off;

  base32_stream_encoder_top #(
    .LINE_LENGTH(LINE_LEN)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_final_byte(in_final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL base32_stream_encoder_top");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else begin
        out_ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.match_char(out_char, out_run_last);
  end

  task automatic send_byte(input logic [7:0] b, input logic f);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_data_byte  = b;
    in_final_byte = f;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(b, f);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.waiting() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int tx_tab[8] = '{0, 66, 0, 23, 0, 66, 0, 23};
    int rx_tab[8] = '{0, 0, 66, 23, 0, 0, 66, 23};
    bit pad_tab[8] = '{1, 0, 1, 0, 1, 0, 1, 0};
    bit lb_tab[8]  = '{1, 1, 0, 0, 1, 0, 1, 1};
    int msg_left;

    sb            = new();
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_off      = 0;
    msg_left      = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_final_byte = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // spare indexes must be ignored
    write_cfg(CFG_SPARE_2, 1'b0);
    write_cfg(CFG_SPARE_3, 1'b1);

    // reset settings: padding on, no line breaks
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hfe, 1'b1);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'hc3, 1'b1);
    send_byte(8'h66, 1'b0);
    send_byte(8'h6f, 1'b0);
    send_byte(8'h6f, 1'b0);
    send_byte(8'h62, 1'b1);
    drain();

    write_cfg(CFG_PAD_ENABLE, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h3c, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);

    // random phases, messages may run across a phase boundary
    for (int p = 0; p < 8; p++) begin
      drain();
      write_cfg(CFG_PAD_ENABLE, pad_tab[p]);
      write_cfg(CFG_LINE_BREAK_ENABLE, lb_tab[p]);
      tx_idle_pct  = tx_tab[p];
      rx_stall_pct = rx_tab[p];
      if (p == 4) hold_off = HOLD_OFF_CYCLES;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (msg_left == 0) begin
          msg_left = ($urandom_range(99) < 25) ? $urandom_range(100, 40)
                                                : $urandom_range(12, 1);
        end
        msg_left--;
        send_byte(8'($urandom_range(255)), msg_left == 0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS base32_stream_encoder_top");
    end else begin
      $display("FAIL base32_stream_encoder_top");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/b32enc_pkg.sv
hw/rtl/b32enc_step.sv
hw/rtl/base32_stream_encoder_top.sv
hw/rtl/b32enc_checker.sv
sim/tb_top.sv
